FILE: design/hex_ascii_command_framer_assert.svh
// Assertion macros for the hex ASCII command framer.
// Taken in by the top level; needs nothing else.
`ifndef HEX_ASCII_COMMAND_FRAMER_ASSERT_SVH
`define HEX_ASCII_COMMAND_FRAMER_ASSERT_SVH

// same-cycle implication, held off during reset
`define HACF_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define HACF_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/hacf_pkg.sv
// Shared types, character codes and helpers for the hex ASCII command framer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hacf_pkg;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ONE  = 8'h31;

	localparam logic [2:0] BLOCK_LEN = 3'd6;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_SEED = 1'b0,
		REG_LEN  = 1'b1
	} hacf_reg_t;

	// one framed payload byte, handed from front to back
	typedef struct packed {
		logic [7:0] value;
		logic       first;
		logic       last;
		logic [7:0] csum;
	} hacf_entry_t;

	typedef struct packed {
		logic pending;
		logic push;
		logic last;
	} hacf_front_stat_t;

	typedef enum logic [2:0] {
		PH_SOH0  = 3'd0,
		PH_SOH1  = 3'd1,
		PH_HI    = 3'd2,
		PH_LO    = 3'd3,
		PH_CK_HI = 3'd4,
		PH_CK_LO = 3'd5,
		PH_CR    = 3'd6,
		PH_LF    = 3'd7
	} hacf_phase_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'h0, nib};
		return (nib < 4'd10) ? (CHAR_ZERO + wide) : (8'h37 + wide);
	endfunction

	// expected character at each place of the command block "01FFFE"
	function automatic logic [7:0] cmd_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = CHAR_ZERO;
			3'd1: c = CHAR_ONE;
			3'd2: c = 8'h46;
			3'd3: c = 8'h46;
			3'd4: c = 8'h46;
			3'd5: c = 8'h45;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/hacf_front.sv
// Front end: takes input words, parses command blocks, frames payload bytes.
// Depends on hacf_pkg; pushes hacf_entry_t words into the queue.
`timescale 1ns / 1ps
`default_nettype none

module hacf_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_valid,
	output logic                           s_ready,
	input  wire logic [7:0]                value,
	input  wire logic                      kind,
	input  wire logic [7:0]                seed,
	input  wire logic [7:0]                len,
	input  wire logic                      q_full,
	output hacf_pkg::hacf_entry_t          entry,
	output hacf_pkg::hacf_front_stat_t     stat
);
	import hacf_pkg::*;

	logic [2:0] pos_q;
	logic       match_q;
	logic       pending_q;
	logic [7:0] count_q;
	logic [7:0] xor_q;

	logic       is_ws, mism, match_nxt, blk_done;
	logic [2:0] pos_inc;
	logic       first, last;
	logic [7:0] xor_base, xor_nxt, cnt_inc;
	logic       accept, cmd_take, pay_take;

	assign s_ready = ~q_full;

	always_comb begin
		accept    = s_valid & s_ready;
		is_ws     = (value == CHAR_CR) || (value == CHAR_LF) || (value == CHAR_SP);
		mism      = (pos_q < BLOCK_LEN) && (value != cmd_char(pos_q));
		match_nxt = match_q & ~mism;
		pos_inc   = pos_q + 3'd1;
		blk_done  = (pos_inc >= BLOCK_LEN);
		first     = (count_q == 8'd0);
		xor_base  = first ? seed : xor_q;
		xor_nxt   = xor_base ^ value;
		cnt_inc   = count_q + 8'd1;
		last      = (cnt_inc == len);
		cmd_take  = accept & ~kind & ~is_ws;
		pay_take  = accept & kind & pending_q;
	end

	always_comb begin
		entry.value  = value;
		entry.first  = first;
		entry.last   = last;
		entry.csum   = xor_nxt;
		stat.pending = pending_q;
		stat.push    = pay_take;
		stat.last    = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			match_q   <= 1'b1;
			pending_q <= 1'b0;
			count_q   <= 8'd0;
			xor_q     <= 8'd0;
		end else begin
			if (cmd_take) begin
				if (blk_done) begin
					pos_q   <= 3'd0;
					match_q <= 1'b1;
					if (match_nxt) begin
						pending_q <= 1'b1;
					end
				end else begin
					pos_q   <= pos_inc;
					match_q <= match_nxt;
				end
			end
			if (pay_take) begin
				xor_q <= xor_nxt;
				if (last) begin
					count_q   <= 8'd0;
					pending_q <= 1'b0;
				end else begin
					count_q <= cnt_inc;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/hacf_queue.sv
// Short FIFO of framed payload words between front and back.
// Depends on hacf_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module hacf_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire hacf_pkg::hacf_entry_t    wr_entry,
	input  wire logic                     pop,
	output hacf_pkg::hacf_entry_t         rd_entry,
	output logic                          full,
	output logic                          not_empty,
	output logic [$clog2(DEPTH+1)-1:0]    level
);
	import hacf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	hacf_entry_t        slot_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic               do_push, do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign level     = cnt_q;
	assign rd_entry  = slot_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/hacf_back.sv
// Back end: turns each framed payload word into its ASCII characters.
// Depends on hacf_pkg; pops words from the queue, one character per cycle out while m_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module hacf_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hacf_pkg::hacf_entry_t q_entry,
	input  wire logic                 q_valid,
	output logic                      q_pop,
	output logic                      m_valid,
	input  wire logic                 m_ready,
	output logic [7:0]                tx_char,
	output logic                      frame_end
);
	import hacf_pkg::*;

	hacf_entry_t  cur_q;
	logic         busy_q;
	hacf_phase_t  phase_q, phase_nxt;
	logic         done, hs, load;

	assign hs     = busy_q & m_ready;
	assign load   = ~busy_q | (hs & done);
	assign q_pop  = load & q_valid;

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		done      = 1'b0;
		unique case (phase_q)
			PH_SOH0:  phase_nxt = PH_SOH1;
			PH_SOH1:  phase_nxt = PH_HI;
			PH_HI:    phase_nxt = PH_LO;
			PH_LO: begin
				if (cur_q.last) begin
					phase_nxt = PH_CK_HI;
				end else begin
					done = 1'b1;
				end
			end
			PH_CK_HI: phase_nxt = PH_CK_LO;
			PH_CK_LO: phase_nxt = PH_CR;
			PH_CR:    phase_nxt = PH_LF;
			PH_LF:    done = 1'b1;
			default:  done = 1'b1;
		endcase
	end

	// character for the current phase
	always_comb begin
		m_valid   = busy_q;
		frame_end = busy_q & (phase_q == PH_LF);
		unique case (phase_q)
			PH_SOH0:  tx_char = CHAR_ZERO;
			PH_SOH1:  tx_char = CHAR_ONE;
			PH_HI:    tx_char = hex_char(cur_q.value[7:4]);
			PH_LO:    tx_char = hex_char(cur_q.value[3:0]);
			PH_CK_HI: tx_char = hex_char(cur_q.csum[7:4]);
			PH_CK_LO: tx_char = hex_char(cur_q.csum[3:0]);
			PH_CR:    tx_char = CHAR_CR;
			PH_LF:    tx_char = CHAR_LF;
			default:  tx_char = CHAR_LF;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_SOH0;
		end else if (load) begin
			busy_q  <= q_valid;
			phase_q <= q_entry.first ? PH_SOH0 : PH_HI;
		end else if (hs) begin
			phase_q <= phase_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: design/hex_ascii_command_framer.sv
// Channel   Dir  Word                       Side info
// s_axis    in   tdata = value (8b)         tuser = kind (0 command char, 1 payload)
// m_axis    out  tdata = tx_char (8b)       tlast = frame_end (closing LF)
// apb       in   0x0 checksum_seed, 0x4 payload_len (8b each)
// The front takes one input word per cycle while the queue has room.
// The back sends one character per cycle while m_axis_tready is high: 2, 4, 6 or 8 characters per payload byte.
// The QUEUE_DEPTH-word queue lets the front keep accepting while the back drains.
// arst_n clears parser, frame and queue state; registers return to seed 1, length 50.
// A stall on m_axis fills the queue, then drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

`include "hex_ascii_command_framer_assert.svh"

module hex_ascii_command_framer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] value
	input  wire logic         s_axis_tuser,   // [0] kind
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // [7:0] tx_char
	output logic              m_axis_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import hacf_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0]        seed_q, len_q;
	hacf_reg_t         reg_sel;
	logic              cfg_wr;
	hacf_entry_t       push_entry, pop_entry;
	hacf_front_stat_t  fstat;
	logic              q_full, q_valid, q_pop;
	logic [CW-1:0]     q_level;

	assign pready  = 1'b1;
	assign reg_sel = hacf_reg_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign prdata  = (reg_sel == REG_LEN) ? {24'h0, len_q} : {24'h0, seed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 8'd1;
			len_q  <= 8'd50;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_SEED: seed_q <= pwdata[7:0];
				REG_LEN:  len_q  <= pwdata[7:0];
				default:  seed_q <= seed_q;
			endcase
		end
	end

	hacf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.value   (s_axis_tdata),
		.kind    (s_axis_tuser),
		.seed    (seed_q),
		.len     (len_q),
		.q_full  (q_full),
		.entry   (push_entry),
		.stat    (fstat)
	);

	hacf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fstat.push),
		.wr_entry  (push_entry),
		.pop       (q_pop),
		.rd_entry  (pop_entry),
		.full      (q_full),
		.not_empty (q_valid),
		.level     (q_level)
	);

	hacf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_entry   (pop_entry),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.tx_char   (m_axis_tdata),
		.frame_end (m_axis_tlast)
	);

	`HACF_ASSERT_NEXT(a_last_clears_pending, clk, arst_n, fstat.push && fstat.last, !fstat.pending, "pending flag survived the last payload byte")
	`HACF_ASSERT_NOW(a_tlast_is_lf, clk, arst_n, m_axis_tlast, m_axis_tvalid && (m_axis_tdata == CHAR_LF), "tlast not on a valid LF")
	`HACF_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, q_level <= CW'(QUEUE_DEPTH), "queue level past depth")

endmodule

`default_nettype wire

FILE: sim/tb_hex_ascii_command_framer.sv
// Self-checking testbench for hex_ascii_command_framer: command parsing, frame
// layout, checksum, register writes and backpressure, against an in-bench predictor.
// Depends on hacf_pkg and the hex_ascii_command_framer RTL.
`timescale 1ns / 1ps

module tb_hex_ascii_command_framer;
	import hacf_pkg::*;

	localparam logic        KIND_CMD      = 1'b0;
	localparam logic        KIND_PAYLOAD  = 1'b1;
	localparam logic [47:0] CMD_BLOCK     = "01FFFE";
	localparam logic [7:0]  CHAR_A        = "A";
	localparam logic [7:0]  FILL_CHAR     = "Z";
	localparam int          SETTLE_CYCLES = 48;
	localparam int          HOLDOFF_LEN   = 400;
	localparam int          STUCK_LIMIT   = 2000;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fend;
	} frame_char_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] value
	logic        s_axis_tuser  = 1'b0;   // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;           // [7:0] tx_char
	logic        m_axis_tlast;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = 3'd0;
	logic [31:0] pwdata        = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	hex_ascii_command_framer uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	in_word_t    pending_words[$];
	frame_char_t expected_chars[$];
	in_word_t    next_word;
	logic        s_busy = 1'b0;
	int          src_gap_pct = 10;
	int          sink_stall_pct = 10;
	int          hold_cycles = 0;
	int          stuck_cycles = 0;
	int          errors = 0;
	int          gen_pos = 0;

	// framer state as the block should hold it
	logic [7:0]  csum_seed = 8'd1;
	logic [7:0]  frame_len = 8'd50;
	logic [2:0]  blk_pos = 3'd0;
	logic        blk_match = 1'b1;
	logic        cmd_pending = 1'b0;
	logic [7:0]  frame_cnt = 8'd0;
	logic [7:0]  run_xor = 8'd0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
		return (nib < 4'd10) ? CHAR_ZERO + {4'h0, nib} : CHAR_A + {4'h0, nib} - 8'd10;
	endfunction

	task automatic expect_char(input logic [7:0] ch, input logic fend);
		frame_char_t c;
		c.ch = ch;
		c.fend = fend;
		expected_chars.push_back(c);
	endtask

	task automatic expect_hex(input logic [7:0] b);
		expect_char(nib_to_ascii(b[7:4]), 1'b0);
		expect_char(nib_to_ascii(b[3:0]), 1'b0);
	endtask

	task automatic frame_word(input logic kind, input logic [7:0] v);
		if (kind == KIND_CMD) begin
			if (v == CHAR_CR || v == CHAR_LF || v == CHAR_SP)
				return;
			if (v != CMD_BLOCK[47 - 8*blk_pos -: 8])
				blk_match = 1'b0;
			blk_pos = blk_pos + 3'd1;
			if (blk_pos >= BLOCK_LEN) begin
				if (blk_match)
					cmd_pending = 1'b1;
				blk_pos = 3'd0;
				blk_match = 1'b1;
			end
			return;
		end
		if (!cmd_pending)
			return;
		if (frame_cnt == 8'd0) begin
			expect_char(CHAR_ZERO, 1'b0);
			expect_char(CHAR_ONE, 1'b0);
			run_xor = csum_seed;
		end
		expect_hex(v);
		run_xor = run_xor ^ v;
		frame_cnt = frame_cnt + 8'd1;
		if (frame_cnt == frame_len) begin
			expect_hex(run_xor);
			expect_char(CHAR_CR, 1'b0);
			expect_char(CHAR_LF, 1'b1);
			cmd_pending = 1'b0;
			frame_cnt = 8'd0;
		end
	endtask

	// source: present the next word at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (!s_busy) begin
			if (arst_n && pending_words.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
				next_word = pending_words.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_word.value;
				s_axis_tuser <= next_word.kind;
				s_busy = 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0)
			hold_cycles--;
		m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= sink_stall_pct);
	end

	// monitor: check output words first, then predict from the accepted input word
	always @(posedge clk) begin
		frame_char_t want;
		if (!arst_n) begin
			stuck_cycles = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("tx_char with nothing expected", m_axis_tdata, 0);
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata !== want.ch)
						report_mismatch("tx_char", m_axis_tdata, want.ch);
					if (m_axis_tlast !== want.fend)
						report_mismatch("frame_end", m_axis_tlast, want.fend);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				frame_word(s_axis_tuser, s_axis_tdata);
				s_busy = 1'b0;
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
					(psel && penable))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb_hex_ascii_command_framer failed");
				$finish;
			end
		end
	end

	task automatic check_reg(input hacf_reg_t r, input logic [7:0] want);
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== {24'h0, want})
			report_mismatch(r == REG_SEED ? "checksum_seed readback" : "payload_len readback",
				rd, {24'h0, want});
	endtask

	task automatic write_reg(input hacf_reg_t r, input logic [7:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= {24'h0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (r == REG_SEED)
			csum_seed = v;
		else
			frame_len = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_reg(r, v);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || s_busy || expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_word(input logic kind, input logic [7:0] v);
		in_word_t w;
		w.kind = kind;
		w.value = v;
		pending_words.push_back(w);
		if (kind == KIND_CMD && v != CHAR_CR && v != CHAR_LF && v != CHAR_SP)
			gen_pos = (gen_pos + 1) % 6;
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(2))
			0: return CHAR_CR;
			1: return CHAR_LF;
			default: return CHAR_SP;
		endcase
	endfunction

	// align to a block boundary, then send "01FFFE", optionally with one char corrupted
	task automatic push_command(input bit spaced, input int broken_at);
		logic [7:0] c;
		while (gen_pos != 0)
			push_word(KIND_CMD, FILL_CHAR);
		for (int i = 0; i < 6; i++) begin
			c = CMD_BLOCK[47 - 8*i -: 8];
			if (i == broken_at)
				c = c ^ (8'h01 << $urandom_range(7));
			if (spaced && $urandom_range(3) == 0)
				push_word(KIND_CMD, blank_char());
			push_word(KIND_CMD, c);
		end
	endtask

	task automatic push_payload(input int n);
		repeat (n) push_word(KIND_PAYLOAD, 8'($urandom_range(255)));
	endtask

	task automatic random_traffic(input int units, input int bytes_per_frame);
		int r;
		repeat (units) begin
			r = $urandom_range(99);
			if (r < 65) begin
				push_command(1'($urandom_range(1)), -1);
				push_payload(bytes_per_frame);
			end else if (r < 75) begin
				push_command(1'b1, $urandom_range(5));
			end else if (r < 88) begin
				repeat ($urandom_range(1, 3)) push_word(KIND_CMD, 8'($urandom_range(255)));
			end else begin
				push_payload($urandom_range(1, 3));
			end
		end
	endtask

	initial begin
		int plen;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_reg(REG_SEED, 8'd1);
		check_reg(REG_LEN, 8'd50);

		// one-byte frames: dropped byte, blanks inside a command, bad block
		write_reg(REG_SEED, 8'hFF);
		write_reg(REG_LEN, 8'd1);
		push_word(KIND_PAYLOAD, 8'h5A);
		push_word(KIND_CMD, "0");
		push_word(KIND_CMD, CHAR_CR);
		push_word(KIND_CMD, "1");
		push_word(KIND_CMD, "F");
		push_word(KIND_CMD, CHAR_LF);
		push_word(KIND_CMD, "F");
		push_word(KIND_CMD, CHAR_SP);
		push_word(KIND_CMD, "F");
		push_word(KIND_CMD, "E");
		push_word(KIND_PAYLOAD, 8'h00);
		push_command(1'b0, 5);
		push_word(KIND_PAYLOAD, 8'hFF);
		push_command(1'b0, -1);
		push_word(KIND_PAYLOAD, 8'hFF);
		wait_idle();

		// second command arrives mid-frame and is absorbed
		write_reg(REG_SEED, 8'h00);
		write_reg(REG_LEN, 8'd2);
		push_command(1'b0, -1);
		push_word(KIND_PAYLOAD, 8'h80);
		push_command(1'b1, -1);
		push_word(KIND_PAYLOAD, 8'h7F);
		push_word(KIND_PAYLOAD, 8'h01);
		for (int i = 0; i < 6; i++)
			push_word(KIND_CMD, (i % 2 == 0) ? 8'h00 : 8'hFF);
		push_word(KIND_PAYLOAD, 8'h33);
		wait_idle();

		// shrink the length mid-frame; a new seed waits for the next frame
		write_reg(REG_SEED, 8'h3C);
		write_reg(REG_LEN, 8'd8);
		push_command(1'b1, -1);
		push_payload(5);
		wait_idle();
		write_reg(REG_LEN, 8'd6);
		write_reg(REG_SEED, 8'h99);
		push_payload(1);
		wait_idle();

		// hold the sink off so the queue fills and the input stalls
		write_reg(REG_SEED, 8'h55);
		write_reg(REG_LEN, 8'd12);
		push_command(1'b0, -1);
		push_payload(12);
		hold_cycles = HOLDOFF_LEN;
		wait_idle();

		for (int k = 0; k < 3; k++) begin
			plen = (k < 2) ? k + 1 : $urandom_range(5, 9);
			write_reg(REG_SEED, 8'($urandom_range(255)));
			write_reg(REG_LEN, 8'(plen));
			if (k == 2) begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			random_traffic((k < 2) ? 2 : 3, plen);
			wait_idle();
			src_gap_pct = 10;
			sink_stall_pct = 10;
		end

		if (errors == 0)
			$display("tb_hex_ascii_command_framer passed");
		else
			$display("tb_hex_ascii_command_framer failed");
		$finish;
	end

endmodule
